// File: src/assert_macros.svh
// Assertion helpers for the sniffer. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/imns_pkg.sv
package imns_pkg;

  localparam int SIG_COUNT = 33;
  localparam int POS_W     = 5;
  localparam logic [POS_W-1:0] POS_LIMIT = 5'd16;

  typedef enum logic [3:0] {
    MIME_NONE = 4'd0,
    MIME_PNG  = 4'd1,
    MIME_TIFF = 4'd2,
    MIME_GIF  = 4'd3,
    MIME_JPEG = 4'd4,
    MIME_WEBP = 4'd5,
    MIME_JXL  = 4'd6,
    MIME_HEIC = 4'd7,
    MIME_AVIF = 4'd8
  } mime_t;

  typedef struct packed {
    logic [SIG_COUNT-1:0] alive;
    logic [POS_W-1:0]     length;
  } imns_status_t;

  localparam mime_t SIG_CODE [SIG_COUNT] = '{
    MIME_PNG, MIME_TIFF, MIME_TIFF, MIME_GIF, MIME_JPEG, MIME_WEBP, MIME_JXL, MIME_JXL,
    MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC,
    MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC,
    MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF,
    MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF
  };

  localparam logic [POS_W-1:0] SIG_OFF [SIG_COUNT] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd8, 5'd0, 5'd0,
    5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
    5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4
  };

  localparam logic [POS_W-1:0] SIG_LEN [SIG_COUNT] = '{
    5'd8, 5'd4, 5'd4, 5'd4, 5'd3, 5'd7, 5'd2, 5'd12,
    5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
    5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8
  };

  // Signature bytes, first byte in the top eight bits, zero padded below.
  localparam logic [95:0] SIG_ID [SIG_COUNT] = '{
    96'h8950_4E47_0D0A_1A0A_0000_0000,
    96'h4D4D_002A_0000_0000_0000_0000,
    96'h4949_2A00_0000_0000_0000_0000,
    96'h4749_4638_0000_0000_0000_0000,
    96'hFFD8_FF00_0000_0000_0000_0000,
    96'h5745_4250_5650_3800_0000_0000,
    96'hFF0A_0000_0000_0000_0000_0000,
    96'h0000_000C_4A58_4C20_0D0A_870A,
    96'h6674_7970_6D69_6631_0000_0000,
    96'h6674_7970_6D73_6631_0000_0000,
    96'h6674_7970_6865_6963_0000_0000,
    96'h6674_7970_6865_6978_0000_0000,
    96'h6674_7970_6865_7678_0000_0000,
    96'h6674_7970_6865_696D_0000_0000,
    96'h6674_7970_6865_6973_0000_0000,
    96'h6674_7970_6176_6963_0000_0000,
    96'h6674_7970_6865_766D_0000_0000,
    96'h6674_7970_6865_7673_0000_0000,
    96'h6674_7970_6176_6373_0000_0000,
    96'h6674_7970_6176_6966_0000_0000,
    96'h6674_7970_6176_6973_0000_0000,
    96'h6674_7970_7269_7378_0000_0000,
    96'h6674_7970_524F_5353_0000_0000,
    96'h6674_7970_7364_7620_0000_0000,
    96'h6674_7970_7373_6331_0000_0000,
    96'h6674_7970_7373_6332_0000_0000,
    96'h6674_7970_5345_4155_0000_0000,
    96'h6674_7970_5345_424B_0000_0000,
    96'h6674_7970_7365_6E76_0000_0000,
    96'h6674_7970_7369_6D73_0000_0000,
    96'h6674_7970_7369_7378_0000_0000,
    96'h6674_7970_7373_7373_0000_0000,
    96'h6674_7970_7576_7675_0000_0000
  };

endpackage

// File: src/image_magic_number_sniffer_unit.sv
// Image magic-number sniffer. Header bytes of a buffer arrive one word per cycle on the
// in_ channel, offset zero first, with in_tlast on the final byte; one result word with
// the image type (0 none, 1 png, 2 tiff, 3 gif, 4 jpeg, 5 webp, 6 jxl, 7 heic, 8 avif)
// leaves on the out_ channel for each buffer. The block takes one byte every cycle; a
// result passes from the input register through the parallel signature compare into
// the result register. Input stalls only when a last byte meets a result word that
// has not yet been taken. Bytes past offset 14 are accepted but compared with nothing.
`include "assert_macros.svh"

module image_magic_number_sniffer_unit
  import imns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] mime_code, [7:4] zero
);

  logic                 in_vld_r, in_vld_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [SIG_COUNT-1:0] alive_r, alive_nxt, alive_upd;
  logic                 out_vld_r, out_vld_nxt;
  mime_t                out_code_r, code;
  logic                 advance;
  logic [POS_W-1:0]     pos_inc;
  imns_status_t         status;

  assign advance   = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign pos_inc   = (pos_r < POS_LIMIT) ? (pos_r + 5'd1) : pos_r;

  imns_match u_match (
    .data_byte (in_byte_r),
    .pos       (pos_r),
    .alive     (alive_r),
    .alive_nxt (alive_upd)
  );

  assign status.alive  = alive_upd;
  assign status.length = pos_inc;

  imns_select u_select (
    .status (status),
    .code   (code)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    pos_nxt     = pos_r;
    alive_nxt   = alive_r;
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (advance) begin
      in_vld_nxt = 1'b0;
      if (in_last_r) begin
        pos_nxt     = '0;
        alive_nxt   = '1;
        out_vld_nxt = 1'b1;
      end else begin
        pos_nxt   = pos_inc;
        alive_nxt = alive_upd;
      end
    end
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pos_r     <= '0;
      alive_r   <= '1;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      pos_r     <= pos_nxt;
      alive_r   <= alive_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && in_last_r) begin
      out_code_r <= code;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_code_r};

  `ASSERT_CLK(a_pos_range, pos_r <= POS_LIMIT, "byte position beyond its limit")
  `ASSERT_CLK(a_clear_after_last, (advance && in_last_r) |=> (pos_r == '0 && (&alive_r)),
              "state not cleared after the last word")
  `ASSERT_CLK(a_ready_when_empty, !out_vld_r |-> in_tready,
              "input stalled with an empty result register")
  `ASSERT_CLK(a_result_source, $rose(out_vld_r) |-> $past(advance && in_last_r),
              "result word without a last input word")
  `ASSERT_CLK(a_code_range, out_vld_r |-> (out_code_r <= MIME_AVIF),
              "result code out of range")

endmodule

// File: src/imns_match.sv
module imns_match
  import imns_pkg::*;
(
  input  logic [7:0]           data_byte,
  input  logic [POS_W-1:0]     pos,
  input  logic [SIG_COUNT-1:0] alive,
  output logic [SIG_COUNT-1:0] alive_nxt
);

  always_comb begin
    logic [3:0] idx;
    logic [6:0] top_bit;
    logic       in_rng;
    alive_nxt = alive;
    for (int i = 0; i < SIG_COUNT; i++) begin
      in_rng  = (pos >= SIG_OFF[i]) && (pos < (SIG_OFF[i] + SIG_LEN[i]));
      idx     = 4'(pos - SIG_OFF[i]);
      top_bit = 7'd95 - {idx, 3'b000};
      if (in_rng && (data_byte != SIG_ID[i][top_bit -: 8])) begin
        alive_nxt[i] = 1'b0;
      end
    end
  end

endmodule

// File: src/imns_select.sv
module imns_select
  import imns_pkg::*;
(
  input  imns_status_t status,
  output mime_t        code
);

  always_comb begin
    code = MIME_NONE;
    for (int i = SIG_COUNT - 1; i >= 0; i--) begin
      if (status.alive[i] && ((SIG_OFF[i] + SIG_LEN[i]) <= status.length)) begin
        code = SIG_CODE[i];
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import imns_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int RUN_ITEMS  = 1300;
  localparam int DRAIN_EVERY = 25;
  localparam int TAIL_CYCLES = 8;

  localparam mime_t MAGIC_KIND [SIG_COUNT] = '{
    MIME_PNG, MIME_TIFF, MIME_TIFF, MIME_GIF, MIME_JPEG, MIME_WEBP, MIME_JXL, MIME_JXL,
    MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC,
    MIME_HEIC, MIME_HEIC, MIME_HEIC, MIME_HEIC,
    MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF,
    MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF, MIME_AVIF
  };

  localparam int MAGIC_AT [SIG_COUNT] = '{
    0, 0, 0, 0, 0, 8, 0, 0,
    4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4,
    4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4
  };

  localparam int MAGIC_LEN [SIG_COUNT] = '{
    8, 4, 4, 4, 3, 7, 2, 12,
    8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8,
    8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8
  };

  // The first byte of each signature sits in the top eight bits.
  localparam logic [95:0] MAGIC_BYTES [SIG_COUNT] = '{
    {8'h89, "PNG", 32'h0D0A1A0A, 32'h0},
    {"MM", 16'h002A, 64'h0},
    {"II", 16'h2A00, 64'h0},
    {"GIF8", 64'h0},
    {24'hFFD8FF, 72'h0},
    {"WEBPVP8", 40'h0},
    {16'hFF0A, 80'h0},
    {32'h0000000C, "JXL ", 32'h0D0A870A},
    {"ftypmif1", 32'h0}, {"ftypmsf1", 32'h0}, {"ftypheic", 32'h0},
    {"ftypheix", 32'h0}, {"ftyphevx", 32'h0}, {"ftypheim", 32'h0},
    {"ftypheis", 32'h0}, {"ftypavic", 32'h0}, {"ftyphevm", 32'h0},
    {"ftyphevs", 32'h0}, {"ftypavcs", 32'h0},
    {"ftypavif", 32'h0}, {"ftypavis", 32'h0}, {"ftyprisx", 32'h0},
    {"ftypROSS", 32'h0}, {"ftypsdv ", 32'h0}, {"ftypssc1", 32'h0},
    {"ftypssc2", 32'h0}, {"ftypSEAU", 32'h0}, {"ftypSEBK", 32'h0},
    {"ftypsenv", 32'h0}, {"ftypsims", 32'h0}, {"ftypsisx", 32'h0},
    {"ftypssss", 32'h0}, {"ftypuvvu", 32'h0}
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } hdr_word_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] data_byte
  logic       in_tlast   = 1'b0;   // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [3:0] mime_code, [7:4] zero

  hdr_word_t   word_queue [$];
  mime_t       mime_expected [$];
  logic [7:0]  hdr_bytes [$];

  logic [POS_W-1:0]     sniff_pos   = '0;
  logic [SIG_COUNT-1:0] sniff_alive = '1;

  int unsigned idle_left    = 0;
  int unsigned calm_in      = 0;
  int unsigned stall_left   = 0;
  int unsigned calm_out     = 0;
  int unsigned lasts_driven = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;

  image_magic_number_sniffer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic mime_step(input logic [7:0] b, input logic last);
    int    p;
    bit    found;
    mime_t code;
    p = sniff_pos;
    for (int i = 0; i < SIG_COUNT; i++) begin
      if (p >= MAGIC_AT[i] && p < MAGIC_AT[i] + MAGIC_LEN[i] &&
          b != MAGIC_BYTES[i][95 - 8 * (p - MAGIC_AT[i]) -: 8])
        sniff_alive[i] = 1'b0;
    end
    if (sniff_pos < POS_LIMIT) sniff_pos = sniff_pos + 1'b1;
    if (last) begin
      found = 1'b0;
      code  = MIME_NONE;
      for (int i = 0; i < SIG_COUNT; i++) begin
        if (!found && sniff_alive[i] && MAGIC_AT[i] + MAGIC_LEN[i] <= int'(sniff_pos)) begin
          found = 1'b1;
          code  = MAGIC_KIND[i];
        end
      end
      mime_expected.push_back(code);
      sniff_pos   = '0;
      sniff_alive = '1;
    end
  endtask

  task automatic push_buffer(input bit drain_first);
    hdr_word_t w;
    for (int k = 0; k < hdr_bytes.size(); k++) begin
      w.data  = hdr_bytes[k];
      w.last  = (k == hdr_bytes.size() - 1);
      w.drain = drain_first && (k == 0);
      word_queue.push_back(w);
    end
  endtask

  task automatic overlay_magic(input int idx);
    int at;
    for (int k = 0; k < MAGIC_LEN[idx]; k++) begin
      at = MAGIC_AT[idx] + k;
      if (at < hdr_bytes.size()) hdr_bytes[at] = MAGIC_BYTES[idx][95 - 8 * k -: 8];
    end
  endtask

  task automatic make_random_buffer();
    int idx;
    int need;
    int blen;
    int r;
    int at;
    hdr_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 20) begin
      blen = $urandom_range(1, 24);
      for (int k = 0; k < blen; k++) hdr_bytes.push_back(8'($urandom));
    end else begin
      idx  = $urandom_range(0, SIG_COUNT - 1);
      need = MAGIC_AT[idx] + MAGIC_LEN[idx];
      r    = $urandom_range(0, 99);
      if (r < 65) blen = $urandom_range(need, 16);
      else if (r < 80) blen = $urandom_range(17, 24);
      else blen = $urandom_range(1, need - 1);
      for (int k = 0; k < blen; k++) hdr_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) overlay_magic($urandom_range(0, SIG_COUNT - 1));
      overlay_magic(idx);
      if ($urandom_range(0, 6) == 0) begin
        at = MAGIC_AT[idx] + $urandom_range(0, MAGIC_LEN[idx] - 1);
        if (at < blen) hdr_bytes[at] = hdr_bytes[at] ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  always @(posedge clk) begin
    hdr_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (idle_left > 0) begin
        idle_left = idle_left - 1;
        in_tvalid <= 1'b0;
      end else if (word_queue.size() > 0 &&
                   !(word_queue[0].drain && lasts_driven != results_seen)) begin
        w = word_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.data;
        in_tlast  <= w.last;
        if (w.last) lasts_driven = lasts_driven + 1;
        if (calm_in > 0) begin
          calm_in = calm_in - 1;
          idle_left = 0;
        end else begin
          if ($urandom_range(0, 99) < 2) calm_in = $urandom_range(20, 80);
          idle_left = next_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (calm_out > 0) begin
        calm_out = calm_out - 1;
      end else if ($urandom_range(0, 99) < 2) begin
        calm_out = $urandom_range(30, 120);
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = next_gap();
      end
    end
  end

  always @(posedge clk) begin
    mime_t want;
    if (!rst_n) begin
      sniff_pos   = '0;
      sniff_alive = '1;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen = results_seen + 1;
        if (mime_expected.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected result word, expected none, actual %0d", $time,
                   out_tdata);
        end else begin
          want = mime_expected.pop_front();
          if (out_tdata[3:0] !== want) begin
            fail_count = fail_count + 1;
            $display("%0t: mime_code mismatch, expected %0d, actual %0d", $time, want,
                     out_tdata[3:0]);
          end
          if (out_tdata[7:4] !== 4'h0) begin
            fail_count = fail_count + 1;
            $display("%0t: padding mismatch, expected 0, actual %0d", $time,
                     out_tdata[7:4]);
          end
        end
      end
      if (in_tvalid && in_tready) mime_step(in_tdata, in_tlast);
    end
  end

  initial begin
    int total;
    int nbuf;

    // Single-byte buffers at both byte extremes.
    hdr_bytes = '{8'h00};
    push_buffer(1'b0);
    hdr_bytes = '{8'hFF};
    push_buffer(1'b0);
    // A full PNG signature followed by a long tail that saturates the position.
    hdr_bytes = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    for (int k = 0; k < 12; k++) hdr_bytes.push_back(8'($urandom));
    push_buffer(1'b0);
    // A JPEG signature cut short by the end of the buffer.
    hdr_bytes = '{8'hFF, 8'hD8};
    push_buffer(1'b0);
    // The shortest signature, exactly filling the buffer.
    hdr_bytes = '{8'hFF, 8'h0A};
    push_buffer(1'b0);

    total = 0;
    nbuf  = 0;
    while (total < RUN_ITEMS) begin
      make_random_buffer();
      push_buffer(nbuf % DRAIN_EVERY == 0);
      total = total + hdr_bytes.size();
      nbuf  = nbuf + 1;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (mime_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
